// ----- src/hwbg_pkg.sv -----
// Shared types, constants and the step schedule of the hashed weight block generator.
// No dependencies; used by hwbg_cfg, hwbg_ctrl, hwbg_dp, the top level and the testbench.
`default_nettype none
package hwbg_pkg;

  localparam int HWBG_MAX_ROWS = 4096;
  localparam int HWBG_MAX_DIM  = 4096;

  localparam int PADDR_W = 5;
  localparam int DATA_W  = 32;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SEED       = 3'd0;
  localparam logic [2:0] REG_ROUND_NUM  = 3'd1;
  localparam logic [2:0] REG_ROW_BASE   = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT  = 3'd3;
  localparam logic [2:0] REG_DIMENSION  = 3'd4;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  localparam logic [63:0] K_ROW   = 64'hD6E8FEB86659FD93;
  localparam logic [63:0] K_COL   = 64'hA0761D6478BD642F;
  localparam logic [63:0] K_ROUND = 64'hE7037ED1A0B428DB;
  localparam logic [63:0] MIX_C0  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_C1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2  = 64'h94D049BB133111EB;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

  // Multiplier operand A select
  localparam logic [2:0] ASEL_ROW = 3'd0;
  localparam logic [2:0] ASEL_COL = 3'd1;
  localparam logic [2:0] ASEL_RK  = 3'd2;
  localparam logic [2:0] ASEL_VLO = 3'd3;
  localparam logic [2:0] ASEL_VHI = 3'd4;

  // Step operations
  localparam logic [3:0] MODE_LOAD   = 4'd0;  // acc = p
  localparam logic [3:0] MODE_KEY    = 4'd1;  // key ^= acc + p<<32
  localparam logic [3:0] MODE_ADD    = 4'd2;  // acc += p<<32
  localparam logic [3:0] MODE_MIX27  = 4'd3;  // v = w ^ (w >> 27), w = acc + p<<32
  localparam logic [3:0] MODE_MIX31  = 4'd4;  // v = w ^ (w >> 31)
  localparam logic [3:0] MODE_PREP   = 4'd5;  // v = t ^ (t >> 30), t = key + C0
  localparam logic [3:0] MODE_BYTES  = 4'd6;  // byte sum of v
  localparam logic [3:0] MODE_WEIGHT = 4'd7;  // fold mod 255, offset
  localparam logic [3:0] MODE_HASH   = 4'd8;  // hash update, result commit

  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] round_num;
    logic [31:0] row_base;
    logic [12:0] row_count;
    logic [12:0] dimension;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              restart;
    logic [STEP_W-1:0] step;
    logic              commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0]  a_sel;
    logic [31:0] b;
    logic [3:0]  mode;
  } op_t;

  // 64x64 products mod 2^64 are built from 32x32 partial products:
  // lo*lo, then the cross terms added into the upper half.
  function automatic op_t step_op(input logic [STEP_W-1:0] step);
    op_t op;
    op.a_sel = ASEL_ROW;
    op.b     = 32'd0;
    op.mode  = MODE_PREP;
    case (step)
      4'd0: begin
        op.a_sel = ASEL_ROW; op.b = K_ROW[31:0]; op.mode = MODE_LOAD;
      end
      4'd1: begin
        op.a_sel = ASEL_ROW; op.b = K_ROW[63:32]; op.mode = MODE_KEY;
      end
      4'd2: begin
        op.a_sel = ASEL_COL; op.b = K_COL[31:0]; op.mode = MODE_LOAD;
      end
      4'd3: begin
        op.a_sel = ASEL_COL; op.b = K_COL[63:32]; op.mode = MODE_KEY;
      end
      4'd4: begin
        op.a_sel = ASEL_RK; op.b = K_ROUND[31:0]; op.mode = MODE_LOAD;
      end
      4'd5: begin
        op.a_sel = ASEL_RK; op.b = K_ROUND[63:32]; op.mode = MODE_KEY;
      end
      4'd6: op.mode = MODE_PREP;
      4'd7: begin
        op.a_sel = ASEL_VLO; op.b = MIX_C1[31:0]; op.mode = MODE_LOAD;
      end
      4'd8: begin
        op.a_sel = ASEL_VLO; op.b = MIX_C1[63:32]; op.mode = MODE_ADD;
      end
      4'd9: begin
        op.a_sel = ASEL_VHI; op.b = MIX_C1[31:0]; op.mode = MODE_MIX27;
      end
      4'd10: begin
        op.a_sel = ASEL_VLO; op.b = MIX_C2[31:0]; op.mode = MODE_LOAD;
      end
      4'd11: begin
        op.a_sel = ASEL_VLO; op.b = MIX_C2[63:32]; op.mode = MODE_ADD;
      end
      4'd12: begin
        op.a_sel = ASEL_VHI; op.b = MIX_C2[31:0]; op.mode = MODE_MIX31;
      end
      4'd13: op.mode = MODE_BYTES;
      4'd14: op.mode = MODE_WEIGHT;
      default: op.mode = MODE_HASH;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

// ----- src/hashed_weight_block_generator_core.sv -----
// Top level of the hashed weight block generator: config registers, sequencer, datapath.
// Depends on hwbg_pkg, hwbg_cfg, hwbg_ctrl and hwbg_dp.
//
//   channel  | ports                                   | role
//   ---------+-----------------------------------------+------------------------------
//   in       | in_valid, in_stall, in_restart          | one request per weight
//   out      | out_valid, out_stall, out_weight, ...   | weight, indexes, hash, last
//   config   | psel, penable, pwrite, paddr, pwdata... | five registers at 4*i, sizes 13 bits
//
// An accepted request runs the 16-step schedule around a single shared 32x32 multiplier;
// a new request is taken only from the cycle after the result is committed.
// Reset (rst_n, synchronous) resets the registers (sizes to 1), positions and the running hash.
// A stalled result holds in the output register; the next request may already run and
// waits at its last step until the register frees.
`default_nettype none
module hashed_weight_block_generator_core #(
  parameter int MAX_ROWS = hwbg_pkg::HWBG_MAX_ROWS,
  parameter int MAX_DIM  = hwbg_pkg::HWBG_MAX_DIM
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_restart,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [7:0]                 out_weight,
  output logic        [11:0]                out_row_index,
  output logic        [11:0]                out_column_index,
  output logic        [63:0]                out_block_hash,
  output logic                              out_last,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hwbg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [hwbg_pkg::DATA_W-1:0]  pwdata,
  output logic      [hwbg_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import hwbg_pkg::*;

  cfg_t     cfg;
  ctl_cmd_t cmd;

  hwbg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hwbg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd)
  );

  hwbg_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_DIM  (MAX_DIM)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .out_weight       (out_weight),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_block_hash   (out_block_hash),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire

// ----- src/hwbg_cfg.sv -----
// APB-style configuration registers of the hashed weight block generator.
// Depends on hwbg_pkg for register indexes and the cfg_t bundle.
`default_nettype none
module hwbg_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hwbg_pkg::PADDR_W-1:0] paddr,
  input  wire logic [hwbg_pkg::DATA_W-1:0]  pwdata,
  output logic      [hwbg_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output hwbg_pkg::cfg_t                    cfg
);
  import hwbg_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (index)
        REG_SEED:       cfg_nxt.seed       = pwdata;
        REG_ROUND_NUM:  cfg_nxt.round_num  = pwdata;
        REG_ROW_BASE:   cfg_nxt.row_base   = pwdata;
        REG_ROW_COUNT:  cfg_nxt.row_count  = pwdata[12:0];
        REG_DIMENSION:  cfg_nxt.dimension  = pwdata[12:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_SEED:       prdata = cfg_r.seed;
      REG_ROUND_NUM:  prdata = cfg_r.round_num;
      REG_ROW_BASE:   prdata = cfg_r.row_base;
      REG_ROW_COUNT:  prdata = {19'd0, cfg_r.row_count};
      REG_DIMENSION:  prdata = {19'd0, cfg_r.dimension};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seed       <= '0;
      cfg_r.round_num  <= '0;
      cfg_r.row_base   <= '0;
      cfg_r.row_count  <= 13'd1;
      cfg_r.dimension  <= 13'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/hwbg_ctrl.sv -----
// Sequencer of the hashed weight block generator: input handshake, step counter,
// output valid. Depends on hwbg_pkg for the command bundle and step count.
`default_nettype none
module hwbg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           in_restart,
  output logic                out_valid,
  input  wire logic           out_stall,
  output hwbg_pkg::ctl_cmd_t  cmd
);
  import hwbg_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              commit;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  // Result slot is free when empty or being taken this cycle.
  assign commit    = (state_r == ST_RUN) && (step_r == LAST_STEP) &&
                     (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  assign cmd.load    = accept;
  assign cmd.restart = in_restart;
  assign cmd.step    = step_r;
  assign cmd.commit  = commit;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (step_r != LAST_STEP) begin
          step_nxt = step_r + 1'b1;
        end else if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN) && (step_r == '0))
    else $error("accepted request did not start at step 0");

  a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && (step_r != LAST_STEP) |=> (step_r == $past(step_r) + 1'b1))
    else $error("step counter did not advance");

  a_rose_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit))
    else $error("result appeared without a commit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !commit)
    else $error("commit over a stalled result");
`endif

endmodule
`default_nettype wire

// ----- src/hwbg_dp.sv -----
// Datapath of the hashed weight block generator: positions, key build, splitmix64
// over one shared 32x32 multiplier, mod-255 fold, FNV-1a hash, result registers.
// Depends on hwbg_pkg for the schedule, constants and bundles.
`default_nettype none
module hwbg_dp #(
  parameter int MAX_ROWS = hwbg_pkg::HWBG_MAX_ROWS,
  parameter int MAX_DIM  = hwbg_pkg::HWBG_MAX_DIM
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hwbg_pkg::cfg_t     cfg,
  input  wire hwbg_pkg::ctl_cmd_t cmd,
  output logic signed [7:0]       out_weight,
  output logic        [11:0]      out_row_index,
  output logic        [11:0]      out_column_index,
  output logic        [63:0]      out_block_hash,
  output logic                    out_last
);
  import hwbg_pkg::*;

  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [ROW_W-1:0] row_pos_r, row_pos_nxt;
  logic [COL_W-1:0] col_pos_r, col_pos_nxt;
  logic [63:0]      hash_r, hash_nxt;

  logic [31:0] grow_r;
  logic [31:0] col_r;
  logic [63:0] acc_r;
  logic [63:0] key_r;
  logic [63:0] vm_r;
  logic [10:0] bsum_r;
  logic [7:0]  wt_r;

  logic signed [7:0] weight_r;
  logic [11:0]       row_idx_r;
  logic [11:0]       col_idx_r;
  logic [63:0]       bhash_r;
  logic              last_r;

  op_t         op;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [63:0] acc_hi;
  logic [63:0] prep_t;
  logic [10:0] byte_sum;
  logic [8:0]  fold;
  logic [8:0]  fold_m;
  logic [63:0] hash_x;
  logic [63:0] hash_p;

  logic [31:0]       rows32, cols32;
  logic              row_end, is_last;
  logic [ROW_W+11:0] row_ext;
  logic [COL_W+11:0] col_ext;

  assign op = step_op(cmd.step);

  always_comb begin
    case (op.a_sel)
      ASEL_ROW: mul_a = grow_r;
      ASEL_COL: mul_a = col_r;
      ASEL_RK:  mul_a = cfg.round_num;
      ASEL_VLO: mul_a = vm_r[31:0];
      ASEL_VHI: mul_a = vm_r[63:32];
      default:  mul_a = '0;
    endcase
  end

  assign prod   = {32'd0, mul_a} * {32'd0, op.b};
  assign acc_hi = acc_r + {prod[31:0], 32'd0};
  assign prep_t = key_r + MIX_C0;

  assign byte_sum = 11'(vm_r[7:0]) + 11'(vm_r[15:8]) + 11'(vm_r[23:16]) +
                    11'(vm_r[31:24]) + 11'(vm_r[39:32]) + 11'(vm_r[47:40]) +
                    11'(vm_r[55:48]) + 11'(vm_r[63:56]);
  // 256 is 1 mod 255: fold the top bits back in, then one subtract.
  assign fold   = 9'(bsum_r[10:8]) + 9'(bsum_r[7:0]);
  assign fold_m = (fold >= 9'd255) ? (fold - 9'd255) : fold;

  // FNV prime is 2^40 + 0x1B3.
  assign hash_x = hash_r ^ {56'd0, wt_r};
  assign hash_p = (hash_x * 64'h1B3) + {hash_x[23:0], 40'd0};

  always_comb begin
    if (cfg.row_count == 13'd0) begin
      rows32 = 32'd1;
    end else if ({19'd0, cfg.row_count} > 32'(MAX_ROWS)) begin
      rows32 = 32'(MAX_ROWS);
    end else begin
      rows32 = {19'd0, cfg.row_count};
    end
    if (cfg.dimension == 13'd0) begin
      cols32 = 32'd1;
    end else if ({19'd0, cfg.dimension} > 32'(MAX_DIM)) begin
      cols32 = 32'(MAX_DIM);
    end else begin
      cols32 = {19'd0, cfg.dimension};
    end
  end

  assign row_end = (32'(col_pos_r) + 32'd1) >= cols32;
  assign is_last = row_end && ((32'(row_pos_r) + 32'd1) >= rows32);
  assign row_ext = {12'd0, row_pos_r};
  assign col_ext = {12'd0, col_pos_r};

  // Position and hash state: restart clears at load, commit advances.
  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    hash_nxt    = hash_r;
    if (cmd.load && cmd.restart) begin
      row_pos_nxt = '0;
      col_pos_nxt = '0;
      hash_nxt    = FNV_BASIS;
    end else if (cmd.commit) begin
      if (is_last) begin
        row_pos_nxt = '0;
        col_pos_nxt = '0;
        hash_nxt    = FNV_BASIS;
      end else if (row_end) begin
        row_pos_nxt = row_pos_r + 1'b1;
        col_pos_nxt = '0;
        hash_nxt    = hash_p;
      end else begin
        col_pos_nxt = col_pos_r + 1'b1;
        hash_nxt    = hash_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      hash_r    <= FNV_BASIS;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      hash_r    <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      grow_r <= cfg.row_base + (cmd.restart ? 32'd0 : 32'(row_pos_r));
      col_r  <= cmd.restart ? 32'd0 : 32'(col_pos_r);
      key_r  <= {cfg.seed, 32'd0};
    end else begin
      case (op.mode)
        MODE_LOAD:   acc_r  <= prod;
        MODE_KEY:    key_r  <= key_r ^ acc_hi;
        MODE_ADD:    acc_r  <= acc_hi;
        MODE_MIX27:  vm_r   <= acc_hi ^ (acc_hi >> 27);
        MODE_MIX31:  vm_r   <= acc_hi ^ (acc_hi >> 31);
        MODE_PREP:   vm_r   <= prep_t ^ (prep_t >> 30);
        MODE_BYTES:  bsum_r <= byte_sum;
        MODE_WEIGHT: wt_r   <= fold_m[7:0] + 8'd129;
        default:     acc_r  <= acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      weight_r  <= wt_r;
      row_idx_r <= row_ext[11:0];
      col_idx_r <= col_ext[11:0];
      bhash_r   <= hash_p;
      last_r    <= is_last;
    end
  end

  assign out_weight       = weight_r;
  assign out_row_index    = row_idx_r;
  assign out_column_index = col_idx_r;
  assign out_block_hash   = bhash_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for hashed_weight_block_generator_core: drives weight requests and
// APB register writes, predicts each weight, index, hash and last flag, and checks the results.
// Depends on hwbg_pkg (register indexes, address and data widths) and the core's RTL only.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import hwbg_pkg::*;

  localparam int          TOTAL_REQUESTS = 1100;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          DRAIN_CYCLES   = 24;
  localparam int          SIZE_CAP       = 4096;
  localparam logic [2:0]  REG_NONE       = 3'd7;  // no register decodes here

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  localparam logic [63:0] ROW_MUL      = 64'hD6E8FEB86659FD93;
  localparam logic [63:0] COL_MUL      = 64'hA0761D6478BD642F;
  localparam logic [63:0] ROUND_MUL    = 64'hE7037ED1A0B428DB;
  localparam logic [63:0] FNV_OFFSET   = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_PRIME    = 64'h00000100000001B3;

  typedef struct {
    logic signed [7:0] weight;
    logic [11:0]       row_index;
    logic [11:0]       column_index;
    logic [63:0]       block_hash;
    logic              last;
  } weight_result_t;

  class weight_scoreboard;
    logic [31:0]    seed, round_num, row_base;
    logic [12:0]    row_count, dimension;
    int unsigned    row_pos, col_pos;
    logic [63:0]    run_hash;
    weight_result_t weights_due[$];
    int             errors, checked, block_ends;

    function new();
      seed = '0; round_num = '0; row_base = '0;
      row_count = 13'd1; dimension = 13'd1;
      row_pos = 0; col_pos = 0; run_hash = FNV_OFFSET;
      errors = 0; checked = 0; block_ends = 0;
    endfunction

    function void write_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_SEED:       seed = data;
        REG_ROUND_NUM:  round_num = data;
        REG_ROW_BASE:   row_base = data;
        REG_ROW_COUNT:  row_count = data[12:0];
        REG_DIMENSION:  dimension = data[12:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(logic [12:0] v);
      if (v == 0) return 1;
      if (v > SIZE_CAP) return SIZE_CAP;
      return v;
    endfunction

    // splitmix64 of the element key, folded to -127..127 as a two's complement byte
    function logic [7:0] weight_of(logic [31:0] grow, logic [31:0] col);
      logic [63:0] v;
      logic [63:0] m;
      v = {seed, 32'd0} ^ ({32'd0, grow} * ROW_MUL) ^ ({32'd0, col} * COL_MUL)
          ^ ({32'd0, round_num} * ROUND_MUL);
      v = v + GOLDEN_GAMMA;
      v = (v ^ (v >> 30)) * MIX_MUL_A;
      v = (v ^ (v >> 27)) * MIX_MUL_B;
      v = v ^ (v >> 31);
      m = v % 64'd255;
      return m[7:0] + 8'd129;
    endfunction

    function void note_request(bit restart);
      int unsigned    rows, cols;
      logic [31:0]    grow;
      logic [7:0]     w;
      bit             row_end, is_last;
      weight_result_t due;
      rows = clamp_size(row_count);
      cols = clamp_size(dimension);
      if (restart) begin
        row_pos = 0; col_pos = 0; run_hash = FNV_OFFSET;
      end
      grow = row_base + row_pos[31:0];
      w = weight_of(grow, col_pos[31:0]);
      run_hash = (run_hash ^ {56'd0, w}) * FNV_PRIME;
      row_end = (col_pos + 1) >= cols;
      is_last = row_end && ((row_pos + 1) >= rows);
      due.weight       = w;
      due.row_index    = row_pos[11:0];
      due.column_index = col_pos[11:0];
      due.block_hash   = run_hash;
      due.last         = is_last;
      weights_due.insert(weights_due.size(), due);
      if (is_last) begin
        row_pos = 0; col_pos = 0; run_hash = FNV_OFFSET;
      end else if (row_end) begin
        row_pos = row_pos + 1; col_pos = 0;
      end else begin
        col_pos = col_pos + 1;
      end
    endfunction

    function void check_result(weight_result_t got);
      weight_result_t due;
      if (weights_due.size() == 0) begin
        $error("result with no request pending: weight %0d row %0d col %0d",
               got.weight, got.row_index, got.column_index);
        errors++;
        return;
      end
      due = weights_due.pop_front();
      checked++;
      if (got.last) block_ends++;
      if (got.weight !== due.weight) begin
        $error("weight: expected %0d, got %0d", due.weight, got.weight); errors++;
      end
      if (got.row_index !== due.row_index) begin
        $error("row_index: expected %0d, got %0d", due.row_index, got.row_index); errors++;
      end
      if (got.column_index !== due.column_index) begin
        $error("column_index: expected %0d, got %0d", due.column_index, got.column_index);
        errors++;
      end
      if (got.block_hash !== due.block_hash) begin
        $error("block_hash: expected %h, got %h", due.block_hash, got.block_hash); errors++;
      end
      if (got.last !== due.last) begin
        $error("last: expected %0b, got %0b", due.last, got.last); errors++;
      end
    endfunction

    function int pending();
      return weights_due.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_restart;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [7:0]       out_weight;
  logic [11:0]             out_row_index;
  logic [11:0]             out_column_index;
  logic [63:0]             out_block_hash;
  logic                    out_last;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [DATA_W-1:0]       pwdata;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  weight_scoreboard sb = new();
  bit               steady;  // no idling on either side while set
  int               requests_sent;
  int               restarts_sent;
  int               reg_writes;
  int               idle_cycles;

  hashed_weight_block_generator_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weight       (out_weight),
    .out_row_index    (out_row_index),
    .out_column_index (out_column_index),
    .out_block_hash   (out_block_hash),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  function automatic logic [12:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 13'($urandom_range(1, 8));
    if (r < 80) return 13'($urandom_range(9, 64));
    if (r < 88) return 13'd0;
    if (r < 92) return 13'd4096;
    if (r < 96) return 13'($urandom_range(4097, 8191));
    return 13'($urandom_range(0, 8191));
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'hFFFF_FFFF - $urandom_range(0, 8);
    return $urandom;
  endfunction

  task automatic send_request(input bit restart);
    int gap;
    gap = steady ? 0 : pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_restart <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(restart);
    requests_sent++;
    if (restart) restarts_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_register(idx, data);
    reg_writes++;
  endtask

  // Hold until every weight is back, then let the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: check accepted results, stall in random runs.
  initial begin
    weight_result_t got;
    int  run_left;
    bit  stalling;
    run_left = 0;
    stalling = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.weight       = out_weight;
        got.row_index    = out_row_index;
        got.column_index = out_column_index;
        got.block_hash   = out_block_hash;
        got.last         = out_last;
        sb.check_result(got);
      end
      if (run_left > 0) begin
        run_left--;
      end else if (stalling || steady) begin
        stalling = 1'b0;
        run_left = $urandom_range(1, 40);
      end else begin
        stalling = 1'b1;
        run_left = pick_idle();
      end
      out_stall <= stalling && run_left > 0 && !steady;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or result moved in %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase_len;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_restart <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 1'b0;
    requests_sent = 0;
    restarts_sent = 0;
    reg_writes = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes give 1x1 blocks: every weight ends its block.
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_drained();

    // All-ones keys, global row wrapping past 2^32, 3x2 block with a restart inside.
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    write_reg(REG_ROUND_NUM, 32'hFFFF_FFFF);
    write_reg(REG_ROW_BASE, 32'hFFFF_FFFE);
    write_reg(REG_ROW_COUNT, 32'd3);
    write_reg(REG_DIMENSION, 32'd2);
    repeat (4) send_request(1'b0);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    wait_drained();

    // Zero sizes act as one.
    write_reg(REG_ROW_COUNT, 32'd0);
    write_reg(REG_DIMENSION, 32'd0);
    repeat (2) send_request(1'b0);
    wait_drained();

    // Oversize clamps to the maximum; upper data bits are dropped.
    write_reg(REG_SEED, 32'd0);
    write_reg(REG_ROUND_NUM, 32'd0);
    write_reg(REG_ROW_BASE, 32'd0);
    write_reg(REG_ROW_COUNT, 32'hFFFF_FFFF);
    write_reg(REG_DIMENSION, 32'd4096);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    wait_drained();

    // Unmapped address is ignored; then shrink the row width mid-block.
    write_reg(REG_NONE, $urandom);
    write_reg(REG_ROW_COUNT, 32'd2);
    write_reg(REG_DIMENSION, 32'd8);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    wait_drained();
    write_reg(REG_DIMENSION, 32'd3);
    repeat (4) send_request(1'b0);
    wait_drained();

    // Random phases: new settings, then a run of 20 to 90 requests with rare restarts.
    while (requests_sent < TOTAL_REQUESTS) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) write_reg(REG_SEED, pick_word());
      if ($urandom_range(0, 3) != 0) write_reg(REG_ROUND_NUM, pick_word());
      if ($urandom_range(0, 3) != 0) write_reg(REG_ROW_BASE, pick_word());
      write_reg(REG_ROW_COUNT, {19'($urandom_range(0, 524287)), pick_size()});
      write_reg(REG_DIMENSION, {19'($urandom_range(0, 524287)), pick_size()});
      if ($urandom_range(0, 9) == 0) write_reg(REG_NONE, $urandom);
      phase_len = $urandom_range(20, 90);
      send_request(1'b1);
      repeat (phase_len) send_request($urandom_range(0, 24) == 0);
      wait_drained();
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d weight requests (%0d restarts) and %0d register writes.",
             requests_sent, restarts_sent, reg_writes);
    $display("Checked %0d weights, %0d of them closing a block; %0d mismatches.",
             sb.checked, sb.block_ends, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
